>>> rtl/cle_pkg.sv
// shared types and constants for the console line editor
`timescale 1ns / 1ps

package cle_pkg;

    localparam int LINE_DEPTH = 32;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int CNT_W      = $clog2(LINE_DEPTH + 1);
    localparam int LIMIT_W    = 6;
    localparam int CMP_W      = 10;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_CONSOLE_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_LIMIT     = 1'd1;

    localparam logic [1:0] KIND_ECHO = 2'd0;
    localparam logic [1:0] KIND_BYTE = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;
    localparam logic [1:0] KIND_ERR  = 2'd3;

    localparam logic [7:0] ERR_NOT_READY = 8'd0;
    localparam logic [7:0] ERR_BAD_LIMIT = 8'd1;
    localparam logic [7:0] ERR_RX_FAULT  = 8'd2;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    typedef enum logic [2:0] {
        CLS_NOT_READY,
        CLS_BAD_LIMIT,
        CLS_FAULT,
        CLS_EOL,
        CLS_ERASE,
        CLS_CHAR
    } t_cls;

    typedef enum logic [3:0] {
        DSEL_CR,
        DSEL_LF,
        DSEL_BS,
        DSEL_SPACE,
        DSEL_RX,
        DSEL_MEM,
        DSEL_COUNT,
        DSEL_ERR_NR,
        DSEL_ERR_LIM,
        DSEL_ERR_FAULT
    } t_dsel;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_CLR
    } t_cnt_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_EOL_CR2,
        S_EOL_LF,
        S_BYTES,
        S_END,
        S_BS_SP,
        S_BS_BS2
    } t_state;

    typedef struct packed {
        logic    capture;
        logic    ptr_clr;
        logic    ptr_inc;
        logic    load;
        t_dsel   dsel;
        logic    last;
        t_cnt_op cnt_op;
    } t_cmd;

    typedef struct packed {
        t_cls cls;
        logic count_zero;
        logic can_store;
        logic ptr_at_count;
        logic ptr_last;
        logic out_ready;
    } t_stat;

endpackage

>>> rtl/console_line_editor.sv
// top level of the console line editor
`timescale 1ns / 1ps

// channel  | dir | handshake                  | payload
// rx item  | in  | i_in_valid / o_in_stall    | i_rx_byte, i_rx_fault
// result   | out | o_out_valid / i_out_stall  | o_out_kind, o_out_data, o_out_last
// config   | in  | i_cfg_we (no wait)         | i_cfg_index, i_cfg_data
//
// an item is taken in idle, classified the next cycle, then one result per
// cycle leaves while the output register is free
// a line end with n stored bytes gives CR, CR, LF, the n bytes and an end result
// the line store is read one entry a cycle, while the output register is free, through its registered read port
// reset disables the console, sets the limit to 32 and empties the line;
// store contents are undefined until written and need no clearing
// a stalled result holds in the output register while the next item is taken

module console_line_editor
    import cle_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // config write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LIMIT_W-1:0]   i_cfg_data,
    // received byte items
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [7:0]           i_rx_byte,
    input  logic                 i_rx_fault,
    // result items
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [1:0]           o_out_kind,
    output logic [7:0]           o_out_data,
    output logic                 o_out_last
);

    // commands down to the datapath, status back up
    t_cmd  cmd;
    t_stat stat;

    cle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // config, line store, count and output register live here
    cle_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_rx_byte   (i_rx_byte),
        .i_rx_fault  (i_rx_fault),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_kind  (o_out_kind),
        .o_out_data  (o_out_data),
        .o_out_last  (o_out_last)
    );

endmodule

>>> rtl/cle_dp.sv
// datapath: config registers, line store, count, read pointer, output register
`timescale 1ns / 1ps

module cle_dp
    import cle_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LIMIT_W-1:0]   i_cfg_data,
    input  logic [7:0]           i_rx_byte,
    input  logic                 i_rx_fault,
    input  logic                 i_out_stall,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    output logic                 o_out_valid,
    output logic [1:0]           o_out_kind,
    output logic [7:0]           o_out_data,
    output logic                 o_out_last
);

    logic               r_console_enable;
    logic [LIMIT_W-1:0] r_line_limit;
    logic [7:0]         r_rx_byte;
    logic               r_rx_fault;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [CNT_W-1:0]   r_ptr;
    logic [CNT_W-1:0]   n_ptr;
    logic [7:0]         r_mem [LINE_DEPTH];
    logic [7:0]         r_rd_data;
    logic               r_out_valid;
    logic [1:0]         r_out_kind;
    logic [7:0]         r_out_data;
    logic               r_out_last;

    logic [CMP_W-1:0]   lim_ext;
    logic [CMP_W-1:0]   depth_ext;
    logic [CMP_W-1:0]   lim_eff;
    logic [CMP_W-1:0]   count_ext;
    logic               out_ready;
    t_cls               cls;
    logic [1:0]         sel_kind;
    logic [7:0]         sel_data;

    // config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_console_enable <= 1'b0;
            r_line_limit     <= LIMIT_W'(32);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CONSOLE_ENABLE: r_console_enable <= i_cfg_data[0];
                CFG_LINE_LIMIT:     r_line_limit     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rx_byte  <= i_rx_byte;
            r_rx_fault <= i_rx_fault;
        end
    end

    // classification of the captured item
    assign lim_ext   = CMP_W'(r_line_limit);
    assign depth_ext = CMP_W'(LINE_DEPTH);
    assign lim_eff   = (lim_ext > depth_ext) ? depth_ext : lim_ext;
    assign count_ext = CMP_W'(r_count);

    always_comb begin
        if (!r_console_enable) begin
            cls = CLS_NOT_READY;
        end else if (lim_eff == '0) begin
            cls = CLS_BAD_LIMIT;
        end else if (r_rx_fault) begin
            cls = CLS_FAULT;
        end else if (r_rx_byte == CH_CR || r_rx_byte == CH_LF) begin
            cls = CLS_EOL;
        end else if (r_rx_byte == CH_BS || r_rx_byte == CH_DEL) begin
            cls = CLS_ERASE;
        end else begin
            cls = CLS_CHAR;
        end
    end

    assign out_ready           = !r_out_valid || !i_out_stall;
    assign o_stat.cls          = cls;
    assign o_stat.count_zero   = (r_count == '0);
    assign o_stat.can_store    = (count_ext + CMP_W'(1) < lim_eff) && (count_ext < depth_ext);
    assign o_stat.ptr_at_count = (r_ptr == r_count);
    assign o_stat.ptr_last     = (r_ptr + CNT_W'(1) == r_count);
    assign o_stat.out_ready    = out_ready;

    // line count
    always_comb begin
        case (i_cmd.cnt_op)
            CNT_INC: n_count = r_count + CNT_W'(1);
            CNT_DEC: n_count = r_count - CNT_W'(1);
            CNT_CLR: n_count = '0;
            default: n_count = r_count;
        endcase
    end

    // read pointer, the store is read at its next value so data is ready in place
    always_comb begin
        if (i_cmd.ptr_clr) begin
            n_ptr = '0;
        end else if (i_cmd.ptr_inc) begin
            n_ptr = r_ptr + CNT_W'(1);
        end else begin
            n_ptr = r_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ptr   <= '0;
        end else begin
            r_count <= n_count;
            r_ptr   <= n_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cnt_op == CNT_INC) begin
            r_mem[r_count[ADDR_W-1:0]] <= r_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[n_ptr[ADDR_W-1:0]];
    end

    // result source
    always_comb begin
        case (i_cmd.dsel)
            DSEL_CR:        begin sel_kind = KIND_ECHO; sel_data = CH_CR;         end
            DSEL_LF:        begin sel_kind = KIND_ECHO; sel_data = CH_LF;         end
            DSEL_BS:        begin sel_kind = KIND_ECHO; sel_data = CH_BS;         end
            DSEL_SPACE:     begin sel_kind = KIND_ECHO; sel_data = CH_SPACE;      end
            DSEL_RX:        begin sel_kind = KIND_ECHO; sel_data = r_rx_byte;     end
            DSEL_MEM:       begin sel_kind = KIND_BYTE; sel_data = r_rd_data;     end
            DSEL_COUNT:     begin sel_kind = KIND_END;  sel_data = 8'(r_count);   end
            DSEL_ERR_NR:    begin sel_kind = KIND_ERR;  sel_data = ERR_NOT_READY; end
            DSEL_ERR_LIM:   begin sel_kind = KIND_ERR;  sel_data = ERR_BAD_LIMIT; end
            DSEL_ERR_FAULT: begin sel_kind = KIND_ERR;  sel_data = ERR_RX_FAULT;  end
            default:        begin sel_kind = KIND_ERR;  sel_data = ERR_NOT_READY; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_kind <= sel_kind;
            r_out_data <= sel_data;
            r_out_last <= i_cmd.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;

    // line never grows past the store
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < CNT_W'(LINE_DEPTH))
        else $error("line count beyond store depth");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> out_ready)
        else $error("output register loaded while stalled");

    // line bytes only come from written entries
    a_read_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && i_cmd.dsel == DSEL_MEM) |-> (r_ptr < r_count))
        else $error("line byte read past count");

    // erase only on a non-empty line
    a_dec_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.cnt_op == CNT_DEC) |-> (r_count != '0))
        else $error("count underflow on erase");

endmodule

>>> rtl/cle_ctrl.sv
// controller state machine sequencing the results of each item
`timescale 1ns / 1ps

module cle_ctrl
    import cle_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output logic  o_in_stall,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EVAL;
            end
            S_EVAL: begin
                case (i_stat.cls)
                    CLS_EOL: begin
                        if (i_stat.out_ready) n_state = S_EOL_CR2;
                    end
                    CLS_ERASE: begin
                        if (i_stat.count_zero) begin
                            n_state = S_IDLE;
                        end else if (i_stat.out_ready) begin
                            n_state = S_BS_SP;
                        end
                    end
                    CLS_CHAR: begin
                        if (!i_stat.can_store || i_stat.out_ready) n_state = S_IDLE;
                    end
                    default: begin
                        if (i_stat.out_ready) n_state = S_IDLE;
                    end
                endcase
            end
            S_EOL_CR2: begin
                if (i_stat.out_ready) n_state = S_EOL_LF;
            end
            S_EOL_LF: begin
                if (i_stat.out_ready) n_state = i_stat.ptr_at_count ? S_END : S_BYTES;
            end
            S_BYTES: begin
                if (i_stat.out_ready && i_stat.ptr_last) n_state = S_END;
            end
            S_END: begin
                if (i_stat.out_ready) n_state = S_IDLE;
            end
            S_BS_SP: begin
                if (i_stat.out_ready) n_state = S_BS_BS2;
            end
            S_BS_BS2: begin
                if (i_stat.out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall    = 1'b1;
        o_cmd.capture = 1'b0;
        o_cmd.ptr_clr = 1'b0;
        o_cmd.ptr_inc = 1'b0;
        o_cmd.load    = 1'b0;
        o_cmd.dsel    = DSEL_CR;
        o_cmd.last    = 1'b0;
        o_cmd.cnt_op  = CNT_HOLD;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_in_valid;
                o_cmd.ptr_clr = i_in_valid;
            end
            S_EVAL: begin
                case (i_stat.cls)
                    CLS_NOT_READY: begin
                        o_cmd.load = i_stat.out_ready;
                        o_cmd.dsel = DSEL_ERR_NR;
                        o_cmd.last = 1'b1;
                    end
                    CLS_BAD_LIMIT: begin
                        o_cmd.load = i_stat.out_ready;
                        o_cmd.dsel = DSEL_ERR_LIM;
                        o_cmd.last = 1'b1;
                    end
                    CLS_FAULT: begin
                        o_cmd.load = i_stat.out_ready;
                        o_cmd.dsel = DSEL_ERR_FAULT;
                        o_cmd.last = 1'b1;
                        if (i_stat.out_ready) o_cmd.cnt_op = CNT_CLR;
                    end
                    CLS_EOL: begin
                        o_cmd.load = i_stat.out_ready;
                        o_cmd.dsel = DSEL_CR;
                    end
                    CLS_ERASE: begin
                        o_cmd.load = i_stat.out_ready && !i_stat.count_zero;
                        o_cmd.dsel = DSEL_BS;
                        if (i_stat.out_ready && !i_stat.count_zero) o_cmd.cnt_op = CNT_DEC;
                    end
                    default: begin
                        o_cmd.load = i_stat.out_ready && i_stat.can_store;
                        o_cmd.dsel = DSEL_RX;
                        o_cmd.last = 1'b1;
                        if (i_stat.out_ready && i_stat.can_store) o_cmd.cnt_op = CNT_INC;
                    end
                endcase
            end
            S_EOL_CR2: begin
                o_cmd.load = i_stat.out_ready;
                o_cmd.dsel = DSEL_CR;
            end
            S_EOL_LF: begin
                o_cmd.load = i_stat.out_ready;
                o_cmd.dsel = DSEL_LF;
            end
            S_BYTES: begin
                o_cmd.load    = i_stat.out_ready;
                o_cmd.dsel    = DSEL_MEM;
                o_cmd.ptr_inc = i_stat.out_ready;
            end
            S_END: begin
                o_cmd.load = i_stat.out_ready;
                o_cmd.dsel = DSEL_COUNT;
                o_cmd.last = 1'b1;
                if (i_stat.out_ready) o_cmd.cnt_op = CNT_CLR;
            end
            S_BS_SP: begin
                o_cmd.load = i_stat.out_ready;
                o_cmd.dsel = DSEL_SPACE;
            end
            S_BS_BS2: begin
                o_cmd.load = i_stat.out_ready;
                o_cmd.dsel = DSEL_BS;
                o_cmd.last = 1'b1;
            end
            default: ;
        endcase
    end

endmodule
